// ===== rtl/lfjc_pkg.sv =====
// Package for the line follower junction controller: mode and side codes,
// register indexes, command and configuration structs, shared constants.
// No dependencies.
`default_nettype none

package lfjc_pkg;

	typedef enum logic [1:0] {
		MODE_TRACK      = 2'd0,
		MODE_SPIN_LEFT  = 2'd1,
		MODE_SPIN_RIGHT = 2'd2,
		MODE_DONE       = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		SIDE_CENTER = 2'd0,
		SIDE_LEFT   = 2'd1,
		SIDE_RIGHT  = 2'd2
	} side_t;

	typedef enum logic [2:0] {
		REG_BLACK_LEVEL    = 3'd0,
		REG_CRUISE_SPEED   = 3'd1,
		REG_TURN_SPEED     = 3'd2,
		REG_SEARCH_SPEED   = 3'd3,
		REG_CROSSING_SPEED = 3'd4,
		REG_MIN_SPEED      = 3'd5,
		REG_RIGHT_GAIN_PCT = 3'd6
	} cfg_reg_t;

	// Defaults for the top-level parameters
	localparam int SPIN_LIMIT_TICKS_DEF = 80;
	localparam int SPIN_MIN_TICKS_DEF   = 6;
	localparam int DEBOUNCE_TICKS_DEF   = 2;
	localparam int REARM_TICKS_DEF      = 4;
	localparam int Q_DEPTH_DEF          = 4;

	// Register reset values
	localparam logic       BLACK_LEVEL_RST    = 1'b1;
	localparam logic [7:0] CRUISE_SPEED_RST   = 8'd68;
	localparam logic [7:0] TURN_SPEED_RST     = 8'd72;
	localparam logic [7:0] SEARCH_SPEED_RST   = 8'd60;
	localparam logic [7:0] CROSSING_SPEED_RST = 8'd58;
	localparam logic [7:0] MIN_SPEED_RST      = 8'd55;
	localparam logic [6:0] RIGHT_GAIN_RST     = 7'd15;

	localparam logic [9:0] SPEED_CAP = 10'd150;
	localparam logic [7:0] PCT_BASE  = 8'd100;
	// floor(2^16 / 100); estimate is low by at most one
	localparam logic [9:0] RECIP_100   = 10'd655;
	localparam int         RECIP_SHIFT = 16;

	typedef struct packed {
		logic       black_level;
		logic [7:0] cruise_speed;
		logic [7:0] turn_speed;
		logic [7:0] search_speed;
		logic [7:0] crossing_speed;
		logic [7:0] min_speed;
		logic [6:0] right_gain_pct;
	} cfg_t;

	// Raw motor command before shaping
	typedef struct packed {
		logic       lrev;
		logic [7:0] lmag;
		logic       rrev;
		logic [7:0] rmag;
		mode_t      mode;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic en0;
		logic en1;
	} q_push_t;

endpackage

`default_nettype wire

// ===== rtl/lfjc_front.sv =====
// Front end: accepts sensor ticks, runs the junction and steering state,
// and pushes zero to two raw motor commands per tick. Uses lfjc_pkg.
`default_nettype none

module lfjc_front #(
	parameter int SPIN_LIMIT_TICKS = lfjc_pkg::SPIN_LIMIT_TICKS_DEF,
	parameter int SPIN_MIN_TICKS   = lfjc_pkg::SPIN_MIN_TICKS_DEF,
	parameter int DEBOUNCE_TICKS   = lfjc_pkg::DEBOUNCE_TICKS_DEF,
	parameter int REARM_TICKS      = lfjc_pkg::REARM_TICKS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire lfjc_pkg::cfg_t cfg,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [1:0]     levels,    // [0] left_level, [1] right_level
	input  wire logic           q_room,
	output lfjc_pkg::q_push_t   push,
	output lfjc_pkg::cmd_t      cmd0,
	output lfjc_pkg::cmd_t      cmd1
);
	import lfjc_pkg::*;

	localparam logic [6:0] SPIN_LIMIT = 7'(SPIN_LIMIT_TICKS);
	localparam logic [6:0] SPIN_MIN   = 7'(SPIN_MIN_TICKS);
	localparam logic [1:0] DEBOUNCE   = 2'(DEBOUNCE_TICKS);
	localparam logic [2:0] REARM      = 3'(REARM_TICKS);

	mode_t      mode_q, mode_d;
	logic [6:0] spin_q, spin_d;
	logic [1:0] junc_q, junc_d;
	logic [1:0] brun_q, brun_d;
	logic [2:0] wrun_q, wrun_d;
	logic [2:0] swrun_q, swrun_d;
	logic       armed_q, armed_d;
	side_t      side_q, side_d;

	logic lb, rb, found, spin_end, junc_hit, accept;

	assign lb       = (levels[0] == cfg.black_level);
	assign rb       = (levels[1] == cfg.black_level);
	assign in_ready = q_room;
	assign accept   = in_valid && in_ready;

	// Next state
	always_comb begin
		mode_d   = mode_q;
		spin_d   = spin_q;
		junc_d   = junc_q;
		brun_d   = brun_q;
		wrun_d   = wrun_q;
		swrun_d  = swrun_q;
		armed_d  = armed_q;
		side_d   = side_q;
		found    = 1'b0;
		spin_end = 1'b0;
		junc_hit = 1'b0;
		case (mode_q)
			MODE_DONE: begin
			end
			MODE_SPIN_LEFT, MODE_SPIN_RIGHT: begin
				if (spin_q != 7'h7f) spin_d = spin_q + 7'd1;
				found = (mode_q == MODE_SPIN_LEFT) ? (lb && !rb) : (!lb && rb);
				if ((spin_d >= SPIN_MIN && found) || spin_d >= SPIN_LIMIT) begin
					mode_d   = MODE_TRACK;
					spin_d   = 7'd0;
					brun_d   = 2'd0;
					wrun_d   = 3'd0;
					armed_d  = 1'b0;
					spin_end = 1'b1;
				end
			end
			default: begin
				if (!lb || !rb) begin
					if (swrun_q < REARM) swrun_d = swrun_q + 3'd1;
					if (swrun_d >= REARM) armed_d = 1'b1;
				end
				if (lb && rb) begin
					if (brun_q != 2'd3) brun_d = brun_q + 2'd1;
					wrun_d = 3'd0;
					if (armed_d && brun_d >= DEBOUNCE) begin
						armed_d  = 1'b0;
						junc_hit = 1'b1;
						if (junc_q != 2'd3) junc_d = junc_q + 2'd1;
						if (junc_d == 2'd1) begin
							mode_d = MODE_SPIN_LEFT;
							spin_d = 7'd0;
						end else if (junc_d == 2'd2) begin
							mode_d = MODE_SPIN_RIGHT;
							spin_d = 7'd0;
						end else begin
							mode_d = MODE_DONE;
						end
					end
				end else begin
					brun_d = 2'd0;
					if (wrun_q != 3'd7) wrun_d = wrun_q + 3'd1;
					if (wrun_d >= REARM) armed_d = 1'b1;
				end
				if (lb && !rb) side_d = SIDE_LEFT;
				else if (!lb && rb) side_d = SIDE_RIGHT;
			end
		endcase
	end

	// Commands for this tick
	always_comb begin
		cmd0      = '0;
		cmd0.mode = mode_d;
		cmd0.last = !spin_end;
		cmd1      = '0;
		cmd1.lmag = cfg.cruise_speed;
		cmd1.rmag = cfg.cruise_speed;
		cmd1.mode = mode_d;
		cmd1.last = 1'b1;
		// a junction that starts a spin gives no command
		push.en0  = accept && !(junc_hit && mode_d != MODE_DONE);
		push.en1  = accept && spin_end;
		case (mode_q)
			MODE_DONE: begin
			end
			MODE_SPIN_LEFT, MODE_SPIN_RIGHT: begin
				cmd0.lrev = (mode_q == MODE_SPIN_LEFT);
				cmd0.rrev = (mode_q == MODE_SPIN_RIGHT);
				cmd0.lmag = cfg.turn_speed;
				cmd0.rmag = cfg.turn_speed;
			end
			default: begin
				if (junc_hit) begin
				end else if (lb && rb) begin
					cmd0.lmag = cfg.crossing_speed;
					cmd0.rmag = cfg.crossing_speed;
				end else if (lb) begin
					cmd0.lrev = 1'b1;
					cmd0.lmag = cfg.turn_speed >> 1;
					cmd0.rmag = cfg.turn_speed;
				end else if (rb) begin
					cmd0.lmag = cfg.turn_speed;
					cmd0.rrev = 1'b1;
					cmd0.rmag = cfg.turn_speed >> 1;
				end else begin
					case (side_d)
						SIDE_LEFT: begin
							cmd0.lrev = 1'b1;
							cmd0.lmag = cfg.search_speed >> 1;
							cmd0.rmag = cfg.search_speed;
						end
						SIDE_RIGHT: begin
							cmd0.lmag = cfg.search_speed;
							cmd0.rrev = 1'b1;
							cmd0.rmag = cfg.search_speed >> 1;
						end
						default: begin
							cmd0.lmag = cfg.cruise_speed;
							cmd0.rmag = cfg.cruise_speed;
						end
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_TRACK;
			spin_q  <= 7'd0;
			junc_q  <= 2'd0;
			brun_q  <= 2'd0;
			wrun_q  <= REARM;
			swrun_q <= 3'd0;
			armed_q <= 1'b0;
			side_q  <= SIDE_CENTER;
		end else if (accept) begin
			mode_q  <= mode_d;
			spin_q  <= spin_d;
			junc_q  <= junc_d;
			brun_q  <= brun_d;
			wrun_q  <= wrun_d;
			swrun_q <= swrun_d;
			armed_q <= armed_d;
			side_q  <= side_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lfjc_queue.sv =====
// Command queue between front and back: two writes and one read per cycle.
// Uses lfjc_pkg.
`default_nettype none

module lfjc_queue #(
	parameter int DEPTH = lfjc_pkg::Q_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lfjc_pkg::q_push_t push,
	input  wire lfjc_pkg::cmd_t    cmd0,
	input  wire lfjc_pkg::cmd_t    cmd1,
	input  wire logic              pop,
	output lfjc_pkg::cmd_t         head,
	output logic                   not_empty,
	output logic                   room
);
	import lfjc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q, wp_next;
	logic [CW-1:0] cnt_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == LAST_PTR) ? '0 : p + PW'(1);
	endfunction

	assign wp_next   = ptr_inc(wp_q);
	assign head      = mem_q[rp_q];
	assign not_empty = (cnt_q != '0);
	assign room      = (cnt_q <= ROOM_MAX);

	always_ff @(posedge clk) begin
		if (push.en0) mem_q[wp_q] <= cmd0;
		if (push.en1) mem_q[wp_next] <= cmd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.en0 && push.en1) wp_q <= ptr_inc(wp_next);
			else if (push.en0) wp_q <= wp_next;
			if (pop) rp_q <= ptr_inc(rp_q);
			cnt_q <= cnt_q + CW'(push.en0) + CW'(push.en1) - CW'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lfjc_back.sv =====
// Back end: shapes queued commands (right gain, minimum speed, cap) in a
// three-stage pipeline ending in the output register. Uses lfjc_pkg.
`default_nettype none

module lfjc_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [7:0]     min_speed,
	input  wire logic [6:0]     right_gain_pct,
	input  wire lfjc_pkg::cmd_t head,
	input  wire logic           head_valid,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [23:0]         out_data,
	output logic                out_last
);
	import lfjc_pkg::*;

	cmd_t        cmd_s1, cmd_s2;
	logic [15:0] prod_s1, prod_s2;
	logic [9:0]  est_s2;
	logic        v1_q, v2_q, adv;
	logic [7:0]  factor;
	logic [15:0] rem;
	logic [9:0]  rq;
	logic [7:0]  lmag, rmag;

	function automatic logic [7:0] shape_mag(input logic [9:0] mag, input logic [7:0] lo);
		logic [9:0] m;
		m = mag;
		if (m != 10'd0 && m < {2'b00, lo}) m = {2'b00, lo};
		if (m > SPEED_CAP) m = SPEED_CAP;
		return m[7:0];
	endfunction

	assign adv    = !out_valid || out_ready;
	assign pop    = adv && head_valid;
	assign factor = PCT_BASE + {1'b0, right_gain_pct};

	// Correct the reciprocal estimate by one where needed
	assign rem  = prod_s2 - 16'(est_s2) * 16'(PCT_BASE);
	assign rq   = est_s2 + 10'(rem >= 16'(PCT_BASE));
	assign lmag = shape_mag({2'b00, cmd_s2.lmag}, min_speed);
	assign rmag = shape_mag(rq, min_speed);

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1   <= head;
			prod_s1  <= 16'(head.rmag) * 16'(factor);
			cmd_s2   <= cmd_s1;
			prod_s2  <= prod_s1;
			est_s2   <= 10'((26'(prod_s1) * 26'(RECIP_100)) >> RECIP_SHIFT);
			out_data <= {4'b0000, cmd_s2.mode, rmag, cmd_s2.rrev && (rmag != 8'd0),
				lmag, cmd_s2.lrev && (lmag != 8'd0)};
			out_last <= cmd_s2.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q      <= 1'b0;
			v2_q      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v1_q      <= head_valid;
			v2_q      <= v1_q;
			out_valid <= v2_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/line_follower_junction_controller_unit.sv =====
// Line follower junction controller, top level: configuration registers,
// front end, command queue and back end. Uses lfjc_pkg and the lfjc_* modules.
// An accepted tick's commands are queued, then pass stages s1, s2 and output.
// Throughput: one tick per cycle while the queue has two free slots; results
// leave one per cycle while m_tready is high (single queue read port).
// Reset: arst_n asynchronously clears control state, loads register defaults.
`default_nettype none

module line_follower_junction_controller_unit #(
	parameter int SPIN_LIMIT_TICKS = lfjc_pkg::SPIN_LIMIT_TICKS_DEF,
	parameter int SPIN_MIN_TICKS   = lfjc_pkg::SPIN_MIN_TICKS_DEF,
	parameter int DEBOUNCE_TICKS   = lfjc_pkg::DEBOUNCE_TICKS_DEF,
	parameter int REARM_TICKS      = lfjc_pkg::REARM_TICKS_DEF,
	parameter int Q_DEPTH          = lfjc_pkg::Q_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// sensor tick stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [0] left_level, [1] right_level, rest zero
	// motor command stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [0] left_reverse, [8:1] left_speed,
	                                    // [9] right_reverse, [17:10] right_speed,
	                                    // [19:18] drive_mode, rest zero
	output logic             m_tlast,   // last_command
	// register writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);
	import lfjc_pkg::*;

	cfg_t    cfg_q;
	q_push_t push;
	cmd_t    cmd0, cmd1, head;
	logic    q_room, q_not_empty, q_pop;

	// Registers take a write every cycle; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.black_level    <= BLACK_LEVEL_RST;
			cfg_q.cruise_speed   <= CRUISE_SPEED_RST;
			cfg_q.turn_speed     <= TURN_SPEED_RST;
			cfg_q.search_speed   <= SEARCH_SPEED_RST;
			cfg_q.crossing_speed <= CROSSING_SPEED_RST;
			cfg_q.min_speed      <= MIN_SPEED_RST;
			cfg_q.right_gain_pct <= RIGHT_GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_BLACK_LEVEL:    cfg_q.black_level    <= cfg_data[0];
				REG_CRUISE_SPEED:   cfg_q.cruise_speed   <= cfg_data;
				REG_TURN_SPEED:     cfg_q.turn_speed     <= cfg_data;
				REG_SEARCH_SPEED:   cfg_q.search_speed   <= cfg_data;
				REG_CROSSING_SPEED: cfg_q.crossing_speed <= cfg_data;
				REG_MIN_SPEED:      cfg_q.min_speed      <= cfg_data;
				REG_RIGHT_GAIN_PCT: cfg_q.right_gain_pct <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	// Front: classify the tick, advance the junction sequence, queue commands.
	// It only takes a tick when the queue can hold both possible commands.
	lfjc_front #(
		.SPIN_LIMIT_TICKS (SPIN_LIMIT_TICKS),
		.SPIN_MIN_TICKS   (SPIN_MIN_TICKS),
		.DEBOUNCE_TICKS   (DEBOUNCE_TICKS),
		.REARM_TICKS      (REARM_TICKS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.levels   (s_tdata[1:0]),
		.q_room   (q_room),
		.push     (push),
		.cmd0     (cmd0),
		.cmd1     (cmd1)
	);

	// Queue: decouple tick intake from the shaping pipeline
	lfjc_queue #(
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.cmd0      (cmd0),
		.cmd1      (cmd1),
		.pop       (q_pop),
		.head      (head),
		.not_empty (q_not_empty),
		.room      (q_room)
	);

	// Back: gain multiply, divide by 100 through a reciprocal, clamp, and
	// hold the result in the output register until the transfer completes.
	lfjc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.min_speed      (cfg_q.min_speed),
		.right_gain_pct (cfg_q.right_gain_pct),
		.head           (head),
		.head_valid     (q_not_empty),
		.pop            (q_pop),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_data       (m_tdata),
		.out_last       (m_tlast)
	);

endmodule

`default_nettype wire

// ===== rtl/lfjc_checker.sv =====
// Port-level checks for the line follower junction controller, bound to
// the top level. Uses lfjc_pkg for the mode codes.
`default_nettype none

module lfjc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic        m_tlast
);
	import lfjc_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_speed_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[8:1] <= 8'd150) && (m_tdata[17:10] <= 8'd150))
		else $error("speed above cap");

	a_reverse_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[0] || m_tdata[8:1] != 8'd0) &&
			(!m_tdata[9] || m_tdata[17:10] != 8'd0))
		else $error("reverse set on zero speed");

	a_finished_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[19:18] == MODE_DONE |-> m_tdata[17:0] == 18'd0 && m_tlast)
		else $error("finished mode without a single stop command");

endmodule

bind line_follower_junction_controller_unit lfjc_checker u_lfjc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire
